@@ hdl/rpt_pkg.sv @@
package rpt_pkg;

  localparam int ENTRIES     = 64;
  localparam int PERM_BITS   = 32;
  localparam int COUNT_WIDTH = 16;

  localparam int EntW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BitW   = (PERM_BITS > 1) ? $clog2(PERM_BITS) : 1;
  localparam int ScanW  = $clog2(PERM_BITS + 1);
  localparam int AddrW  = EntW + BitW;
  localparam int FieldW = 16;
  localparam int KeyW   = 3 * FieldW;
  localparam int MaskW  = 32;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  localparam logic [2:0] ACT_PLAN_ALLOW   = 3'd0;
  localparam logic [2:0] ACT_ADD          = 3'd1;
  localparam logic [2:0] ACT_PLAN_RELEASE = 3'd2;
  localparam logic [2:0] ACT_RELEASE      = 3'd3;
  localparam logic [2:0] ACT_CLEAR_ALL    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_ADD_DROP  = 3'd4;

  typedef struct packed {
    logic [2:0]        action;
    logic [FieldW-1:0] source_type;
    logic [FieldW-1:0] target_type;
    logic [FieldW-1:0] object_class;
    logic [MaskW-1:0]  perm_mask;
    logic [MaskW-1:0]  direct_mask;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [MaskW-1:0] granted_mask;
    logic [MaskW-1:0] commit_mask;
    logic             key_hit;
  } rsp_t;

  typedef struct packed {
    logic            hit;
    logic            has_free;
    logic [EntW-1:0] hit_idx;
    logic [EntW-1:0] free_idx;
  } lookup_t;

  typedef struct packed {
    logic            clear_all;
    logic            alloc;
    logic            free;
    logic [EntW-1:0] idx;
  } key_upd_t;

  typedef struct packed {
    logic nonzero;
    logic at_max;
    logic le_one;
  } cnt_flags_t;

endpackage

@@ hdl/rpt_keys.sv @@
module rpt_keys import rpt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmp_en_i,
  input  logic [KeyW-1:0] key_i,
  input  key_upd_t        upd_i,
  output lookup_t         lookup_o
);

  logic [ENTRIES-1:0] used_q, used_d;
  logic [ENTRIES-1:0] match_q, match_d;
  logic [ENTRIES-1:0] free_q;
  logic [ENTRIES-1:0] match_first, free_first;
  logic [KeyW-1:0]    key_q [ENTRIES];

  function automatic logic [EntW-1:0] onehot_enc(input logic [ENTRIES-1:0] oh);
    logic [EntW-1:0] r;
    r = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (oh[i]) begin
        r = r | EntW'(i);
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i] = used_q[i] && (key_q[i] == key_i);
    end
  end

  // lowest set bit
  assign match_first = match_q & (~match_q + ENTRIES'(1));
  assign free_first  = free_q & (~free_q + ENTRIES'(1));

  assign lookup_o.hit      = |match_q;
  assign lookup_o.has_free = |free_q;
  assign lookup_o.hit_idx  = onehot_enc(match_first);
  assign lookup_o.free_idx = onehot_enc(free_first);

  always_comb begin
    used_d = used_q;
    if (upd_i.clear_all) begin
      used_d = '0;
    end else if (upd_i.alloc) begin
      used_d[upd_i.idx] = 1'b1;
    end else if (upd_i.free) begin
      used_d[upd_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      match_q <= '0;
      free_q  <= '0;
    end else begin
      used_q <= used_d;
      if (cmp_en_i) begin
        match_q <= match_d;
        free_q  <= ~used_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.alloc) begin
      key_q[upd_i.idx] <= key_i;
    end
  end

endmodule

@@ hdl/rpt_count_mem.sv @@
module rpt_count_mem import rpt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [AddrW-1:0]       rd_addr_i,
  output logic [COUNT_WIDTH-1:0] rd_data_o,
  input  logic                   wr_en_i,
  input  logic [AddrW-1:0]       wr_addr_i,
  input  logic [COUNT_WIDTH-1:0] wr_data_i
);

  localparam int MemDepth = ENTRIES * (2 ** BitW);

  logic [COUNT_WIDTH-1:0] mem_q [MemDepth];
  logic [COUNT_WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ hdl/rpt_count_alu.sv @@
module rpt_count_alu import rpt_pkg::*; (
  input  logic [COUNT_WIDTH-1:0] cnt_i,
  input  logic                   step_i,
  input  logic                   dec_i,
  output logic [COUNT_WIDTH-1:0] cnt_o,
  output cnt_flags_t             flags_o
);

  logic [COUNT_WIDTH-1:0] sum;
  logic                   apply;

  assign flags_o.nonzero = (cnt_i != '0);
  assign flags_o.at_max  = (cnt_i == CountMax);
  assign flags_o.le_one  = (cnt_i[COUNT_WIDTH-1:1] == '0);

  // saturate at both ends
  assign sum   = cnt_i + (dec_i ? CountMax : COUNT_WIDTH'(1));
  assign apply = step_i && (dec_i ? flags_o.nonzero : !flags_o.at_max);
  assign cnt_o = apply ? sum : cnt_i;

endmodule

@@ hdl/refcounted_permission_table_unit.sv @@
// channel | direction | handshake                 | payload
// request | in        | in_valid_i / in_ready_o   | in_req_i  (req_t)
// result  | out       | out_valid_o / out_ready_i | out_rsp_o (rsp_t)
//
// an item skips the count scan for an empty mask, clear_all or an unknown action;
// else the scan runs over all PERM_BITS counts, one count per cycle, through
// the shared saturating counter and the read port and write port of the count ram
// reset clears the entry valid bits; count rows are zeroed when an entry is allocated
// the next request is taken while a result still waits; the sequencer holds at
// its final step until the output register is free
module refcounted_permission_table_unit import rpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_SEL  = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  req_t                   req_q;
  lookup_t                lookup, look_q;
  logic [EntW-1:0]        t_q;
  logic [ScanW-1:0]       scan_q;
  logic                   rv_q;
  logic [BitW-1:0]        rb_q;
  logic [PERM_BITS-1:0]   owned_q, owned_d, reqm_q, reqm_d, grant_q, grant_d;
  logic                   ovf_q, ovf_d, live_q, live_d;
  logic                   out_valid_q;
  rsp_t                   out_q, rsp_d;
  key_upd_t               upd_d, upd;

  logic [PERM_BITS-1:0]   perm_v;
  logic                   is_alw, is_add, is_prel, is_rel, act_scan, no_room;
  logic                   scan_end, fin_go, pb, db, rq_bit, wr_en, rd_en;
  logic [COUNT_WIDTH-1:0] rd_data, cnt, cnt_new;
  cnt_flags_t             flags;

  assign perm_v   = req_q.perm_mask[PERM_BITS-1:0];
  assign is_alw   = (req_q.action == ACT_PLAN_ALLOW);
  assign is_add   = (req_q.action == ACT_ADD);
  assign is_prel  = (req_q.action == ACT_PLAN_RELEASE);
  assign is_rel   = (req_q.action == ACT_RELEASE);
  assign act_scan = (perm_v != '0) && (is_alw || is_add || is_prel || is_rel);
  assign no_room  = !look_q.hit && !look_q.has_free;
  assign scan_end = (scan_q == ScanW'(PERM_BITS));
  assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  rpt_keys u_keys (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmp_en_i (state_q == S_CMP),
    .key_i    ({req_q.source_type, req_q.target_type, req_q.object_class}),
    .upd_i    (upd),
    .lookup_o (lookup)
  );

  assign rd_en = (state_q == S_SCAN) && !scan_end;
  assign wr_en = rv_q && ((is_add && !no_room) || (is_rel && look_q.hit));

  rpt_count_mem u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i ({t_q, scan_q[BitW-1:0]}),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i ({t_q, rb_q}),
    .wr_data_i (cnt_new)
  );

  // a fresh entry starts from zero counts
  assign cnt = look_q.hit ? rd_data : '0;
  assign pb  = perm_v[rb_q];
  assign db  = req_q.direct_mask[rb_q];

  rpt_count_alu u_alu (
    .cnt_i   (cnt),
    .step_i  (pb && (is_add || is_rel)),
    .dec_i   (is_rel),
    .cnt_o   (cnt_new),
    .flags_o (flags)
  );

  assign rq_bit = pb && (!db || flags.nonzero);

  always_comb begin
    owned_d = owned_q;
    reqm_d  = reqm_q;
    grant_d = grant_q;
    ovf_d   = ovf_q;
    live_d  = live_q;
    if (rv_q) begin
      owned_d[rb_q] = flags.nonzero;
      reqm_d[rb_q]  = rq_bit;
      grant_d[rb_q] = pb && flags.le_one;
      ovf_d  = ovf_q || (is_alw && rq_bit && flags.at_max) || (is_add && pb && flags.at_max);
      live_d = live_q || (cnt_new != '0);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CMP;
      end
      S_CMP:  state_d = S_SEL;
      S_SEL:  state_d = act_scan ? S_SCAN : S_FIN;
      S_SCAN: begin
        if (scan_end) state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_d         = '0;
    upd_d         = '0;
    upd_d.idx     = t_q;
    rsp_d.key_hit = look_q.hit;
    case (req_q.action)
      ACT_PLAN_ALLOW: begin
        if (perm_v == '0) begin
          rsp_d.status = ST_EMPTY;
        end else if (reqm_q == '0) begin
          rsp_d.status = ST_OK;
        end else if (no_room) begin
          rsp_d.status = ST_NO_SPACE;
        end else if (ovf_q) begin
          rsp_d.status = ST_OVERFLOW;
        end else begin
          rsp_d.granted_mask = MaskW'(reqm_q);
          rsp_d.commit_mask  = MaskW'(reqm_q & ~owned_q);
        end
      end
      ACT_ADD: begin
        if (perm_v == '0) begin
          rsp_d.status = ST_EMPTY;
        end else if (no_room) begin
          rsp_d.status = ST_ADD_DROP;
        end else begin
          rsp_d.status = ovf_q ? ST_OVERFLOW : ST_OK;
          upd_d.alloc  = !look_q.hit;
        end
      end
      ACT_PLAN_RELEASE: begin
        if (perm_v == '0) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.granted_mask = MaskW'(grant_q);
        end
      end
      ACT_RELEASE: begin
        if (perm_v == '0) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          upd_d.free = look_q.hit && !live_q;
        end
      end
      ACT_CLEAR_ALL: begin
        rsp_d.key_hit   = 1'b0;
        upd_d.clear_all = 1'b1;
      end
      default: begin
        rsp_d.key_hit = 1'b0;
      end
    endcase
  end

  assign upd = fin_go ? upd_d : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SEL) begin
        scan_q <= '0;
        rv_q   <= 1'b0;
      end else if (state_q == S_SCAN) begin
        rv_q <= !scan_end;
        if (!scan_end) scan_q <= scan_q + ScanW'(1);
      end else begin
        rv_q <= 1'b0;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_req_i;
    if (state_q == S_SEL) begin
      look_q  <= lookup;
      t_q     <= lookup.hit ? lookup.hit_idx : lookup.free_idx;
      owned_q <= '0;
      reqm_q  <= '0;
      grant_q <= '0;
      ovf_q   <= 1'b0;
      live_q  <= 1'b0;
    end else begin
      owned_q <= owned_d;
      reqm_q  <= reqm_d;
      grant_q <= grant_d;
      ovf_q   <= ovf_d;
      live_q  <= live_d;
    end
    if (state_q == S_SCAN) rb_q <= scan_q[BitW-1:0];
    if (fin_go) out_q <= rsp_d;
  end

endmodule

@@ hdl/rpt_checker.sv @@
module rpt_checker import rpt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == ST_OK) || (out_rsp_o.status == ST_EMPTY) ||
      (out_rsp_o.status == ST_NO_SPACE) || (out_rsp_o.status == ST_OVERFLOW) ||
      (out_rsp_o.status == ST_ADD_DROP))
    else $error("bad status");

  a_commit_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.commit_mask & ~out_rsp_o.granted_mask) == '0)
    else $error("commit outside grant");

  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_OK) |-> out_rsp_o.commit_mask == '0)
    else $error("commit on failed request");

endmodule

bind refcounted_permission_table_unit rpt_checker u_rpt_checker (.*);
